FILE: sv/apb_pkg.sv
// Shared types and constants for the arpeggio pattern builder.
`default_nettype none
package apb_pkg;

  localparam int PITCH_W = 7;
  localparam int VEL_W   = 7;
  localparam int POS_W   = 5;
  localparam int STYLE_W = 4;
  localparam int RETRIG_W = 2;
  localparam int CFG_W   = 4;

  localparam logic [STYLE_W-1:0] ST_UP        = 4'd0;
  localparam logic [STYLE_W-1:0] ST_DOWN      = 4'd1;
  localparam logic [STYLE_W-1:0] ST_UPDOWN    = 4'd2;
  localparam logic [STYLE_W-1:0] ST_DOWNUP    = 4'd3;
  localparam logic [STYLE_W-1:0] ST_UP_N_DOWN = 4'd4;
  localparam logic [STYLE_W-1:0] ST_DOWN_N_UP = 4'd5;
  localparam logic [STYLE_W-1:0] ST_CONVERGE  = 4'd6;
  localparam logic [STYLE_W-1:0] ST_DIVERGE   = 4'd7;
  localparam logic [STYLE_W-1:0] ST_CONDIV    = 4'd8;
  localparam logic [STYLE_W-1:0] ST_PINKY_UP  = 4'd9;
  localparam logic [STYLE_W-1:0] ST_PINKY_UD  = 4'd10;
  localparam logic [STYLE_W-1:0] ST_THUMB_UP  = 4'd11;
  localparam logic [STYLE_W-1:0] ST_THUMB_UD  = 4'd12;
  localparam logic [STYLE_W-1:0] ST_ORDER     = 4'd13;

  localparam logic [RETRIG_W-1:0] RT_OFF   = 2'd0;
  localparam logic [RETRIG_W-1:0] RT_EVERY = 2'd1;

  localparam logic CFG_IDX_STYLE  = 1'b0;
  localparam logic CFG_IDX_RETRIG = 1'b1;

  // Classified event as it sits in the queue.
  typedef struct packed {
    logic                is_on;
    logic [PITCH_W-1:0]  pitch;
    logic [VEL_W-1:0]    vel;
  } evt_t;

endpackage
`default_nettype wire

FILE: sv/arpeggio_pattern_builder.sv
// Top level of the arpeggio pattern builder: config registers and the two engines.
//
// Each note event first updates the held table, then (for every style but arrival
// order) the table is sorted by odd/even transposition passes, then the pattern is
// emitted at one beat per cycle while the output is not stalled. A two-entry
// event queue in front accepts new events while the table engine is busy. A
// note-on for a pitch already held only updates its velocity and emits nothing.
`default_nettype none
module arpeggio_pattern_builder #(
  parameter int MAX_HELD = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_wr_en,
  input  wire                         cfg_index,
  input  wire [apb_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_kind,
  input  wire [apb_pkg::PITCH_W-1:0]  in_note_pitch,
  input  wire [apb_pkg::VEL_W-1:0]    in_note_velocity,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [apb_pkg::PITCH_W-1:0] out_pattern_pitch,
  output logic [apb_pkg::VEL_W-1:0]   out_pattern_velocity,
  output logic [apb_pkg::POS_W-1:0]   out_position,
  output logic                        out_last,
  output logic                        out_restart,
  output logic                        out_empty_res
);

  logic [apb_pkg::STYLE_W-1:0]  arp_style_r;
  logic [apb_pkg::RETRIG_W-1:0] retrig_mode_r;
  logic          q_valid, q_pop;
  apb_pkg::evt_t q_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arp_style_r   <= apb_pkg::ST_UP;
      retrig_mode_r <= apb_pkg::RT_OFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apb_pkg::CFG_IDX_STYLE:  arp_style_r <= cfg_wdata[apb_pkg::STYLE_W-1:0];
        apb_pkg::CFG_IDX_RETRIG: retrig_mode_r <= cfg_wdata[apb_pkg::RETRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_note_pitch    (in_note_pitch),
    .in_note_velocity (in_note_velocity),
    .q_valid          (q_valid),
    .q_evt            (q_evt),
    .q_pop            (q_pop)
  );

  apb_back #(.MAX_HELD(MAX_HELD)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_evt                (q_evt),
    .q_pop                (q_pop),
    .arp_style            (arp_style_r),
    .retrig_mode          (retrig_mode_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pattern_pitch    (out_pattern_pitch),
    .out_pattern_velocity (out_pattern_velocity),
    .out_position         (out_position),
    .out_last             (out_last),
    .out_restart          (out_restart),
    .out_empty_res        (out_empty_res)
  );

endmodule
`default_nettype wire

FILE: sv/apb_front.sv
// Front end: classify note events and queue them for the table engine.
`default_nettype none
module apb_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire                        in_kind,
  input  wire [apb_pkg::PITCH_W-1:0] in_note_pitch,
  input  wire [apb_pkg::VEL_W-1:0]   in_note_velocity,
  output logic                       q_valid,
  output apb_pkg::evt_t              q_evt,
  input  wire                        q_pop
);

  apb_pkg::evt_t evt_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  assign in_stall = (fill_r == 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_evt    = evt_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 2'd1;
    else if (pop && !push) fill_nxt = fill_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  // A note-on with zero velocity is a release.
  always_ff @(posedge clk) begin
    if (push) begin
      evt_r[wr_ptr_r].is_on <= in_kind && (in_note_velocity != '0);
      evt_r[wr_ptr_r].pitch <= in_note_pitch;
      evt_r[wr_ptr_r].vel   <= in_note_velocity;
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_r != 2'd3)
    else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> fill_r == $past(fill_r) + 2'd1) else $error("fill count slip");

endmodule
`default_nettype wire

FILE: sv/apb_back.sv
// Back end: held-note table, in-place sort and pattern sequencer.
`default_nettype none
module apb_back #(
  parameter int MAX_HELD = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_valid,
  input  apb_pkg::evt_t               q_evt,
  output logic                        q_pop,
  input  wire [apb_pkg::STYLE_W-1:0]  arp_style,
  input  wire [apb_pkg::RETRIG_W-1:0] retrig_mode,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [apb_pkg::PITCH_W-1:0] out_pattern_pitch,
  output logic [apb_pkg::VEL_W-1:0]   out_pattern_velocity,
  output logic [apb_pkg::POS_W-1:0]   out_position,
  output logic                        out_last,
  output logic                        out_restart,
  output logic                        out_empty_res
);

  localparam int IW = $clog2(MAX_HELD);
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int PW = $clog2(MAX_HELD);
  localparam int KW = ($clog2(4 * MAX_HELD) > apb_pkg::POS_W) ?
                      $clog2(4 * MAX_HELD) : apb_pkg::POS_W;
  localparam int AW = KW + 1;

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_SORT, S_EMIT} state_t;

  state_t state_r, state_nxt;
  apb_pkg::evt_t ev_r;
  // Slots at and above the count are don't-care, so no empty marker is kept.
  logic [apb_pkg::PITCH_W-1:0] pit_r [MAX_HELD];
  logic [apb_pkg::PITCH_W-1:0] pit_nxt [MAX_HELD];
  logic [apb_pkg::VEL_W-1:0]   vel_r [MAX_HELD];
  logic [apb_pkg::VEL_W-1:0]   vel_nxt [MAX_HELD];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pass_r;
  logic [KW-1:0] k_r;
  logic          restart_r, restart_nxt;
  logic [MAX_HELD-1:0] hit, above;
  logic          hit_any, full, do_sort, desc;

  logic [AW-1:0] n_a, k_a, m_a, h_a, j_a, base_a, len_a, idx_a;
  logic          odd, seq_last;
  logic [IW-1:0] idx;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign full  = (cnt_r == CW'(MAX_HELD));
  assign desc  = (arp_style == apb_pkg::ST_DOWN) || (arp_style == apb_pkg::ST_DOWNUP) ||
                 (arp_style == apb_pkg::ST_DOWN_N_UP);

  always_comb begin
    for (int i = 0; i < MAX_HELD; i++) begin
      hit[i] = (CW'(i) < cnt_r) && (pit_r[i] == ev_r.pitch);
    end
    above[0] = hit[0];
    for (int i = 1; i < MAX_HELD; i++) begin
      above[i] = above[i-1] || hit[i];
    end
    hit_any = above[MAX_HELD-1];
  end

  // Table update and one odd/even transposition pass per sort cycle.
  always_comb begin
    for (int i = 0; i < MAX_HELD; i++) begin
      pit_nxt[i] = pit_r[i];
      vel_nxt[i] = vel_r[i];
    end
    cnt_nxt = cnt_r;
    restart_nxt = restart_r;
    case (state_r)
      S_UPD: begin
        restart_nxt = 1'b0;
        if (ev_r.is_on) begin
          if (hit_any) begin
            for (int i = 0; i < MAX_HELD; i++) begin
              if (hit[i]) vel_nxt[i] = ev_r.vel;
            end
          end else if (full) begin
            // evict slot 0 (the oldest only while the table is unsorted), shift down, append
            for (int i = 0; i < MAX_HELD - 1; i++) begin
              pit_nxt[i] = pit_r[i+1];
              vel_nxt[i] = vel_r[i+1];
            end
            pit_nxt[MAX_HELD-1] = ev_r.pitch;
            vel_nxt[MAX_HELD-1] = ev_r.vel;
            restart_nxt = (retrig_mode == apb_pkg::RT_EVERY);
          end else begin
            for (int i = 0; i < MAX_HELD; i++) begin
              if (CW'(i) == cnt_r) begin
                pit_nxt[i] = ev_r.pitch;
                vel_nxt[i] = ev_r.vel;
              end
            end
            cnt_nxt = cnt_r + CW'(1);
            restart_nxt = (retrig_mode == apb_pkg::RT_EVERY) || (cnt_r == '0);
          end
        end else if (hit_any) begin
          for (int i = 0; i < MAX_HELD - 1; i++) begin
            if (above[i]) begin
              pit_nxt[i] = pit_r[i+1];
              vel_nxt[i] = vel_r[i+1];
            end
          end
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_SORT: begin
        for (int i = 0; i < MAX_HELD - 1; i++) begin
          if ((i % 2) == int'(pass_r[0]) && (CW'(i + 1) < cnt_r)) begin
            if (desc ? (pit_r[i] < pit_r[i+1]) : (pit_r[i] > pit_r[i+1])) begin
              pit_nxt[i]   = pit_r[i+1];
              pit_nxt[i+1] = pit_r[i];
              vel_nxt[i]   = vel_r[i+1];
              vel_nxt[i+1] = vel_r[i];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Pattern length and table slot for step k.
  always_comb begin
    n_a    = AW'(cnt_r);
    k_a    = AW'(k_r);
    m_a    = k_a >> 1;
    h_a    = n_a >> 1;
    odd    = n_a[0];
    len_a  = n_a;
    idx_a  = k_a;
    j_a    = '0;
    base_a = '0;
    if (n_a == AW'(1)) begin
      len_a = AW'(1);
      idx_a = '0;
    end else begin
      case (arp_style)
        apb_pkg::ST_UPDOWN, apb_pkg::ST_DOWNUP: begin
          len_a = (n_a << 1) - AW'(2);
          idx_a = (k_a < n_a) ? k_a : (n_a << 1) - AW'(2) - k_a;
        end
        apb_pkg::ST_UP_N_DOWN, apb_pkg::ST_DOWN_N_UP: begin
          len_a = n_a << 1;
          idx_a = (k_a < n_a) ? k_a : (n_a << 1) - AW'(1) - k_a;
        end
        apb_pkg::ST_CONVERGE: begin
          idx_a = k_a[0] ? n_a - AW'(1) - m_a : m_a;
        end
        apb_pkg::ST_DIVERGE, apb_pkg::ST_CONDIV: begin
          if (arp_style == apb_pkg::ST_CONDIV) begin
            base_a = h_a << 1;
            len_a  = (h_a << 2) + AW'(odd);
          end
          if (arp_style == apb_pkg::ST_CONDIV && k_a < base_a) begin
            idx_a = k_a[0] ? n_a - AW'(1) - m_a : m_a;
          end else if (odd && k_a == base_a) begin
            idx_a = h_a;
          end else begin
            j_a   = k_a - base_a - AW'(odd);
            idx_a = j_a[0] ? n_a - h_a + (j_a >> 1) : h_a - AW'(1) - (j_a >> 1);
          end
        end
        apb_pkg::ST_PINKY_UP, apb_pkg::ST_PINKY_UD: begin
          len_a = (arp_style == apb_pkg::ST_PINKY_UD) ? (n_a - AW'(1)) << 2
                                                     : (n_a - AW'(1)) << 1;
          if (!k_a[0]) idx_a = n_a - AW'(1);
          else idx_a = (m_a < n_a - AW'(1)) ? m_a : (n_a << 1) - AW'(3) - m_a;
        end
        apb_pkg::ST_THUMB_UP, apb_pkg::ST_THUMB_UD: begin
          len_a = (arp_style == apb_pkg::ST_THUMB_UD) ? (n_a - AW'(1)) << 2
                                                     : (n_a - AW'(1)) << 1;
          if (!k_a[0]) idx_a = '0;
          else idx_a = (m_a < n_a - AW'(1)) ? m_a + AW'(1) : (n_a << 1) - AW'(2) - m_a;
        end
        default: begin
        end
      endcase
    end
    seq_last = (k_a + AW'(1) == len_a);
    idx      = idx_a[IW-1:0];
  end

  assign do_sort = (arp_style <= apb_pkg::ST_THUMB_UD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_UPD;
      S_UPD: begin
        if (ev_r.is_on && hit_any) state_nxt = S_IDLE;
        else if (cnt_nxt != '0 && do_sort) state_nxt = S_SORT;
        else state_nxt = S_EMIT;
      end
      S_SORT: if (pass_r == PW'(MAX_HELD - 1)) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          if (cnt_r == '0 || seq_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      pass_r    <= '0;
      k_r       <= '0;
      restart_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      restart_r <= restart_nxt;
      if (q_pop) ev_r <= q_evt;
      for (int i = 0; i < MAX_HELD; i++) begin
        pit_r[i] <= pit_nxt[i];
        vel_r[i] <= vel_nxt[i];
      end
      if (state_r == S_UPD) begin
        pass_r <= '0;
        k_r    <= '0;
      end
      if (state_r == S_SORT) pass_r <= pass_r + PW'(1);
      if (state_r == S_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        k_r       <= k_r + KW'(1);
        if (cnt_r == '0) begin
          out_pattern_pitch    <= '0;
          out_pattern_velocity <= '0;
          out_position         <= '0;
          out_last             <= 1'b1;
          out_restart          <= 1'b0;
          out_empty_res        <= 1'b1;
        end else begin
          out_pattern_pitch    <= pit_r[idx];
          out_pattern_velocity <= vel_r[idx];
          out_position         <= k_r[apb_pkg::POS_W-1:0];
          out_last             <= seq_last;
          out_restart          <= restart_r;
          out_empty_res        <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_HELD)) else $error("held count overflow");
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && out_position == '0 && !out_restart)
    else $error("empty beat malformed");
  a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SORT |-> cnt_r != '0) else $error("sort on empty table");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_UPD) else $error("pop outside idle");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the arpeggio pattern builder: directed and random note events checked per beat.
`timescale 1ns / 1ps
module tb_top;

  localparam int HELD_MAX = 8;
  localparam int SETTLE_CYCLES = 3 + HELD_MAX + 4 * (HELD_MAX - 1) + 20;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic EV_OFF = 1'b0;
  localparam logic EV_ON  = 1'b1;

  typedef struct packed {
    logic [apb_pkg::PITCH_W-1:0] pitch;
    logic [apb_pkg::VEL_W-1:0]   vel;
    logic [apb_pkg::POS_W-1:0]   pos;
    logic                        last;
    logic                        restart;
    logic                        empty;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [apb_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_kind = 1'b0;
  logic [apb_pkg::PITCH_W-1:0] in_note_pitch = '0;
  logic [apb_pkg::VEL_W-1:0] in_note_velocity = '0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid, out_last, out_restart, out_empty_res;
  wire [apb_pkg::PITCH_W-1:0] out_pattern_pitch;
  wire [apb_pkg::VEL_W-1:0] out_pattern_velocity;
  wire [apb_pkg::POS_W-1:0] out_position;

  arpeggio_pattern_builder #(.MAX_HELD(HELD_MAX)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_note_pitch(in_note_pitch), .in_note_velocity(in_note_velocity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pattern_pitch(out_pattern_pitch), .out_pattern_velocity(out_pattern_velocity),
    .out_position(out_position), .out_last(out_last), .out_restart(out_restart),
    .out_empty_res(out_empty_res)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state
  logic [7:0] tbl_pitch [HELD_MAX];
  logic [apb_pkg::VEL_W-1:0] tbl_vel [HELD_MAX];
  int tbl_count;
  logic [apb_pkg::STYLE_W-1:0] cur_style;
  logic [apb_pkg::RETRIG_W-1:0] cur_retrig;
  beat_t expected_beats [$];
  int errors = 0;
  int cycles = 0;
  bit stall_heavy = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic sort_held(bit descending);
    bit swapped;
    logic [7:0] tp;
    logic [apb_pkg::VEL_W-1:0] tv;
    swapped = 1'b1;
    while (swapped) begin
      swapped = 1'b0;
      for (int i = 0; i + 1 < tbl_count; i++) begin
        if (descending ? (tbl_pitch[i] < tbl_pitch[i+1]) : (tbl_pitch[i] > tbl_pitch[i+1])) begin
          tp = tbl_pitch[i]; tbl_pitch[i] = tbl_pitch[i+1]; tbl_pitch[i+1] = tp;
          tv = tbl_vel[i]; tbl_vel[i] = tbl_vel[i+1]; tbl_vel[i+1] = tv;
          swapped = 1'b1;
        end
      end
    end
  endtask

  task automatic drop_held(int at);
    for (int i = at; i + 1 < tbl_count; i++) begin
      tbl_pitch[i] = tbl_pitch[i+1];
      tbl_vel[i] = tbl_vel[i+1];
    end
    tbl_count--;
    tbl_pitch[tbl_count] = 8'd128;
  endtask

  task automatic predict_pattern(logic kind, logic [apb_pkg::PITCH_W-1:0] p,
                                 logic [apb_pkg::VEL_W-1:0] v);
    bit rs;
    int n, h, s;
    int seq [$];
    beat_t b;
    rs = 1'b0;
    if (kind == EV_ON && v != 0) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_pitch[i] == {1'b0, p}) begin
          tbl_vel[i] = v;
          return;
        end
      end
      if (tbl_count >= HELD_MAX) drop_held(0);
      tbl_pitch[tbl_count] = {1'b0, p};
      tbl_vel[tbl_count] = v;
      tbl_count++;
      rs = (cur_retrig == apb_pkg::RT_EVERY) || (tbl_count == 1);
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_pitch[i] == {1'b0, p}) begin
          drop_held(i);
          break;
        end
      end
    end
    n = tbl_count;
    h = n / 2;
    s = cur_style;
    if (n == 0) begin
      b = '{pitch: '0, vel: '0, pos: '0, last: 1'b1, restart: 1'b0, empty: 1'b1};
      expected_beats.push_back(b);
      return;
    end
    if (s == apb_pkg::ST_DOWN || s == apb_pkg::ST_DOWNUP || s == apb_pkg::ST_DOWN_N_UP)
      sort_held(1'b1);
    else if (s <= apb_pkg::ST_THUMB_UD) sort_held(1'b0);
    if (n == 1) seq.push_back(0);
    else begin
      case (s)
        apb_pkg::ST_UPDOWN, apb_pkg::ST_DOWNUP: begin
          for (int i = 0; i < n; i++) seq.push_back(i);
          for (int i = n - 2; i >= 1; i--) seq.push_back(i);
        end
        apb_pkg::ST_UP_N_DOWN, apb_pkg::ST_DOWN_N_UP: begin
          for (int i = 0; i < n; i++) seq.push_back(i);
          for (int i = n - 1; i >= 0; i--) seq.push_back(i);
        end
        apb_pkg::ST_CONVERGE, apb_pkg::ST_DIVERGE, apb_pkg::ST_CONDIV: begin
          if (s != apb_pkg::ST_DIVERGE)
            for (int i = 0; i < h; i++) begin
              seq.push_back(i); seq.push_back(n - 1 - i);
            end
          if (n % 2) seq.push_back(h);
          if (s != apb_pkg::ST_CONVERGE)
            for (int i = h; i > 0; i--) begin
              seq.push_back(i - 1); seq.push_back(n - i);
            end
        end
        apb_pkg::ST_PINKY_UP, apb_pkg::ST_PINKY_UD: begin
          for (int i = 0; i + 1 < n; i++) begin
            seq.push_back(n - 1); seq.push_back(i);
          end
          if (s == apb_pkg::ST_PINKY_UD)
            for (int i = 0; i + 1 < n; i++) begin
              seq.push_back(n - 1); seq.push_back(n - 2 - i);
            end
        end
        apb_pkg::ST_THUMB_UP, apb_pkg::ST_THUMB_UD: begin
          for (int i = 1; i < n; i++) begin
            seq.push_back(0); seq.push_back(i);
          end
          if (s == apb_pkg::ST_THUMB_UD)
            for (int i = 0; i + 1 < n; i++) begin
              seq.push_back(0); seq.push_back(n - 1 - i);
            end
        end
        default: for (int i = 0; i < n; i++) seq.push_back(i);
      endcase
    end
    foreach (seq[k]) begin
      b.pitch = tbl_pitch[seq[k]][apb_pkg::PITCH_W-1:0];
      b.vel = tbl_vel[seq[k]];
      b.pos = k[apb_pkg::POS_W-1:0];
      b.last = (k == seq.size() - 1);
      b.restart = rs;
      b.empty = 1'b0;
      expected_beats.push_back(b);
    end
  endtask

  // Valid stays high after acceptance when the next event follows with no gap.
  task automatic send_event(logic kind, logic [apb_pkg::PITCH_W-1:0] p,
                            logic [apb_pkg::VEL_W-1:0] v, bit nogap = 1'b0);
    int g;
    g = nogap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_note_pitch <= p;
    in_note_velocity <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pattern(kind, p, v);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [apb_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == apb_pkg::CFG_IDX_STYLE) cur_style = val;
    else cur_retrig = val[apb_pkg::RETRIG_W-1:0];
  endtask

  task automatic test_directed();
    write_reg(apb_pkg::CFG_IDX_STYLE, apb_pkg::ST_UP);
    write_reg(apb_pkg::CFG_IDX_RETRIG, 4'(apb_pkg::RT_OFF));
    send_event(EV_OFF, 7'd60, 7'd0);          // release with nothing held
    send_event(EV_ON, 7'd127, 7'd127);        // only note: restart
    send_event(EV_ON, 7'd0, 7'd1);
    send_event(EV_ON, 7'd127, 7'd55);         // known pitch: velocity only
    send_event(EV_ON, 7'd0, 7'd0);            // on with zero velocity releases
    send_event(EV_OFF, 7'd99, 7'd127);        // unknown pitch release
    for (int i = 0; i < 9; i++) send_event(EV_ON, 7'(10 * i + 5), 7'(i + 1), 1'b1);
    send_event(EV_OFF, 7'd127, 7'd0);
    send_event(EV_OFF, 7'd85, 7'd0);
    write_reg(apb_pkg::CFG_IDX_RETRIG, 4'd3);
    send_event(EV_ON, 7'd42, 7'd64);
    write_reg(apb_pkg::CFG_IDX_RETRIG, 4'(apb_pkg::RT_EVERY));
    send_event(EV_ON, 7'd43, 7'd64);
  endtask

  task automatic test_styles();
    for (int s = 0; s < 16; s++) begin
      write_reg(apb_pkg::CFG_IDX_STYLE, 4'(s));
      write_reg(apb_pkg::CFG_IDX_RETRIG, 4'($urandom_range(0, 3)));
      send_event(EV_ON, 7'($urandom_range(0, 127)), 7'($urandom_range(1, 127)));
      send_event(EV_OFF, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic test_random();
    int r;
    logic [apb_pkg::PITCH_W-1:0] p;
    for (int blk = 0; blk < 10; blk++) begin
      write_reg(apb_pkg::CFG_IDX_STYLE, 4'($urandom_range(0, 15)));
      write_reg(apb_pkg::CFG_IDX_RETRIG, 4'($urandom_range(0, 3)));
      stall_heavy = blk[0];
      for (int k = 0; k < 16; k++) begin
        r = $urandom_range(0, 99);
        // Mostly reuse a held pitch so releases and updates hit.
        if (tbl_count > 0 && r < 55)
          p = tbl_pitch[$urandom_range(0, tbl_count - 1)][apb_pkg::PITCH_W-1:0];
        else
          p = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 55) send_event(EV_ON, p, 7'($urandom_range(1, 127)));
        else if (r < 65) send_event(EV_ON, p, 7'd0);
        else send_event(EV_OFF, p, 7'($urandom_range(0, 127)));
      end
    end
  endtask

  // Receiver stall
  initial begin
    int g;
    forever begin
      @(posedge clk);
      g = $urandom_range(0, 99);
      if (stall_heavy && g > 97) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= stall_heavy ? (g >= 60) : (g >= 90);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{pitch: out_pattern_pitch, vel: out_pattern_velocity, pos: out_position,
              last: out_last, restart: out_restart, empty: out_empty_res};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (want.empty) begin
          got.pitch = '0; got.vel = '0;
          want.pitch = '0; want.vel = '0;
        end
        if (got.pitch !== want.pitch)
          $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
        if (got.vel !== want.vel)
          $display("%0t: velocity exp %0d got %0d", $time, want.vel, got.vel);
        if (got.pos !== want.pos)
          $display("%0t: position exp %0d got %0d", $time, want.pos, got.pos);
        if (got.last !== want.last)
          $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
        if (got.restart !== want.restart)
          $display("%0t: restart exp %0b got %0b", $time, want.restart, got.restart);
        if (got.empty !== want.empty)
          $display("%0t: empty exp %0b got %0b", $time, want.empty, got.empty);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < HELD_MAX; i++) begin
      tbl_pitch[i] = 8'd128;
      tbl_vel[i] = '0;
    end
    tbl_count = 0;
    cur_style = apb_pkg::ST_UP;
    cur_retrig = apb_pkg::RT_OFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_styles();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
